@@ rtl/sapt_pkg.sv @@
// shared request/response types and op codes for the affinity task picker
`timescale 1ns / 1ps
`default_nettype none

package sapt_pkg;

   localparam int CORE_W  = 2;
   localparam int PRIO_W  = 5;
   localparam int MASK_W  = 4;
   localparam int READY_W = 32;

   typedef enum logic [1:0] {
      OP_RESTRICT = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_YIELD    = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef struct packed {
      logic [READY_W-1:0] ready_set;
      logic [MASK_W-1:0]  core_mask;
      logic [PRIO_W-1:0]  prio;
      logic [CORE_W-1:0]  core;
      op_type             op;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] allowed_cores;
      logic              switched;
      logic [PRIO_W-1:0] picked_prio;
      logic              picked_valid;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/sapt_pick.sv @@
// candidate masking and priority encoding for one core's schedule or yield
`timescale 1ns / 1ps
`default_nettype none

module sapt_pick
   import sapt_pkg::*;
#(
   parameter int PRIORITIES = 32,
   parameter int PIDX_W     = $clog2(PRIORITIES)
) (
   input  op_type                 op,
   input  logic [PRIORITIES-1:0]  allowed_row,
   input  logic [PRIORITIES-1:0]  ready,
   input  logic [PRIORITIES-1:0]  running,
   input  logic                   cur_valid,
   input  logic [PIDX_W-1:0]      cur_prio,
   output logic                   pick_valid,
   output logic [PIDX_W-1:0]      pick_prio,
   output logic [PRIORITIES-1:0]  running_next
);

   logic [PRIORITIES-1:0] cur_bit;
   logic [PRIORITIES-1:0] others;
   logic [PRIORITIES-1:0] tasks;
   logic [PRIORITIES-1:0] lower;
   logic [PRIORITIES-1:0] pick_bit;
   logic                  use_lower;
   logic                  lower_hit;
   logic [PIDX_W-1:0]     lower_idx;
   logic                  task_hit;
   logic [PIDX_W-1:0]     task_idx;

   // yield on an empty core is a plain schedule
   assign use_lower = (op == OP_YIELD) && cur_valid;

   always_comb begin
      for (int i = 0; i < PRIORITIES; i++) begin
         cur_bit[i] = cur_valid && (cur_prio == PIDX_W'(i));
      end
      others = running & ~cur_bit;
      tasks  = ready & allowed_row & ~others;
      for (int i = 0; i < PRIORITIES; i++) begin
         // non-idle candidates below the current priority
         lower[i] = use_lower && tasks[i] && (i != 0) && (PIDX_W'(i) < cur_prio);
      end
   end

   always_comb begin
      lower_hit = 1'b0;
      lower_idx = '0;
      task_hit  = 1'b0;
      task_idx  = '0;
      for (int i = 0; i < PRIORITIES; i++) begin
         if (lower[i]) begin
            lower_hit = 1'b1;
            lower_idx = PIDX_W'(i);
         end
         if (tasks[i]) begin
            task_hit = 1'b1;
            task_idx = PIDX_W'(i);
         end
      end
   end

   assign pick_valid = lower_hit || task_hit;
   assign pick_prio  = lower_hit ? lower_idx : task_idx;

   always_comb begin
      for (int i = 0; i < PRIORITIES; i++) begin
         pick_bit[i] = pick_valid && (pick_prio == PIDX_W'(i));
      end
   end

   assign running_next = others | pick_bit;

endmodule

`default_nettype wire

@@ rtl/smp_affinity_priority_task_picker.sv @@
// top level: request register, per-core scheduler state and response register
//
//   channel  dir  ports                       payload
//   req      in   req_tvalid/tready/tdata/tuser  op, core, prio, core_mask, ready_set
//   rsp      out  rsp_tvalid/tready/tdata     picked_valid, picked_prio, switched,
//                                             allowed_cores
//
// one request per cycle is taken while req_tready is high; its response is registered
// the running set and current priorities update as a request leaves the request
// register, so the next request already sees them
// reset clears all state at once: every priority allowed, nothing running
// a stalled response holds the request register, and req_tready drops only when
// both registers are full and rsp_tready is low
`timescale 1ns / 1ps
`default_nettype none

module smp_affinity_priority_task_picker
   import sapt_pkg::*;
#(
   parameter int CORES      = 4,
   parameter int PRIORITIES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // core[1:0], prio[6:2], core_mask[10:7], ready_set[42:11], zeros above
   input  wire logic [47:0] req_tdata,
   // op[1:0]
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // picked_valid[0], picked_prio[5:1], switched[6], allowed_cores[10:7], zeros above
   output      logic [15:0] rsp_tdata
);

   localparam int PIDX_W = $clog2(PRIORITIES);
   localparam int CIDX_W = (CORES > 1) ? $clog2(CORES) : 1;
   localparam logic [6:0] PRIO_LIMIT = 7'(PRIORITIES);
   localparam logic [4:0] CORE_LIMIT = 5'(CORES);

   req_type               req_ff, req_in;
   logic                  req_valid_ff, req_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [PRIORITIES-1:0] allowed_ff [CORES];
   logic [PRIORITIES-1:0] allowed_in [CORES];
   logic [PRIORITIES-1:0] running_ff, running_in;
   logic [CORES-1:0]      cur_valid_ff, cur_valid_in;
   logic [PIDX_W-1:0]     cur_prio_ff [CORES];
   logic [PIDX_W-1:0]     cur_prio_in [CORES];

   logic                  accept;
   logic                  advance;
   logic                  prio_ok;
   logic                  core_ok;
   logic                  sched_go;
   logic [PIDX_W-1:0]     pidx;
   logic [CIDX_W-1:0]     cidx;
   logic [15:0]           mask16;
   logic [63:0]           ready64;
   logic [PRIORITIES-1:0] ready_ext;
   logic                  pick_valid;
   logic [PIDX_W-1:0]     pick_prio;
   logic [PRIORITIES-1:0] running_next;
   logic [MASK_W-1:0]     query_cores;
   logic [5:0]            prio6;
   logic                  changed;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      req_in.op        = op_type'(req_tuser);
      req_in.core      = req_tdata[1:0];
      req_in.prio      = req_tdata[6:2];
      req_in.core_mask = req_tdata[10:7];
      req_in.ready_set = req_tdata[42:11];
   end

   assign prio_ok   = 7'(req_ff.prio) < PRIO_LIMIT;
   assign core_ok   = 5'(req_ff.core) < CORE_LIMIT;
   // out-of-range selectors are steered to entry zero, their effect is masked
   assign pidx      = prio_ok ? PIDX_W'(7'(req_ff.prio)) : '0;
   assign cidx      = core_ok ? CIDX_W'(5'(req_ff.core)) : '0;
   assign mask16    = 16'(req_ff.core_mask);
   assign ready64   = 64'(req_ff.ready_set);
   assign ready_ext = ready64[PRIORITIES-1:0];
   assign sched_go  = core_ok && ((req_ff.op == OP_SCHEDULE) || (req_ff.op == OP_YIELD));

   sapt_pick #(
      .PRIORITIES (PRIORITIES),
      .PIDX_W     (PIDX_W)
   ) u_pick (
      .op           (req_ff.op),
      .allowed_row  (allowed_ff[cidx]),
      .ready        (ready_ext),
      .running      (running_ff),
      .cur_valid    (cur_valid_ff[cidx]),
      .cur_prio     (cur_prio_ff[cidx]),
      .pick_valid   (pick_valid),
      .pick_prio    (pick_prio),
      .running_next (running_next)
   );

   always_comb begin
      query_cores = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (i < CORES) begin
            query_cores[i] = prio_ok && allowed_ff[i][pidx];
         end
      end
   end

   assign prio6   = 6'(pick_prio);
   assign changed = (cur_valid_ff[cidx] != pick_valid) ||
                    (pick_valid && (cur_prio_ff[cidx] != pick_prio));

   always_comb begin
      rsp_in = '0;
      case (req_ff.op)
         OP_QUERY: begin
            rsp_in.allowed_cores = query_cores;
         end
         OP_SCHEDULE, OP_YIELD: begin
            if (sched_go) begin
               rsp_in.picked_valid = pick_valid;
               rsp_in.picked_prio  = pick_valid ? prio6[PRIO_W-1:0] : '0;
               rsp_in.switched     = changed;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_comb begin
      allowed_in   = allowed_ff;
      running_in   = running_ff;
      cur_valid_in = cur_valid_ff;
      cur_prio_in  = cur_prio_ff;
      if (advance) begin
         if ((req_ff.op == OP_RESTRICT) && prio_ok) begin
            // cores beyond the four mask bits lose the priority
            for (int i = 0; i < CORES; i++) begin
               allowed_in[i][pidx] = (i < MASK_W) && mask16[i];
            end
         end
         if (sched_go) begin
            running_in         = running_next;
            cur_valid_in[cidx] = pick_valid;
            cur_prio_in[cidx]  = pick_prio;
         end
      end
   end

   always_comb begin
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         running_ff   <= '0;
         cur_valid_ff <= '0;
         for (int i = 0; i < CORES; i++) begin
            allowed_ff[i]  <= '1;
            cur_prio_ff[i] <= '0;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
         cur_valid_ff <= cur_valid_in;
         allowed_ff   <= allowed_in;
         cur_prio_ff  <= cur_prio_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_ff);

   // the number of running priorities equals the number of busy cores
   a_running_matches_cores: assert property (@(posedge clock) disable iff (reset)
      $countones(running_ff) == $countones(cur_valid_ff))
      else $error("running set out of step with busy cores");

   // a held request must not be overwritten
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_ff)))
      else $error("pending request lost");

   // the running set and busy flags change only when a request leaves the request register
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(running_ff) && $stable(cur_valid_ff)))
      else $error("scheduler state moved without a request");

   // an empty core reports priority zero
   a_empty_prio_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.picked_valid) |-> (rsp_ff.picked_prio == '0))
      else $error("nonzero priority on an empty core");

endmodule

`default_nettype wire
